// ----- rtl/pose_error_scorer_macros.svh -----
// Assertion macros shared by the pose error scorer checker.
// No dependencies; included by the files that assert.
`ifndef POSE_ERROR_SCORER_MACROS_SVH
`define POSE_ERROR_SCORER_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define PES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("label failed");
// Next-cycle implication, disabled while reset is asserted.
`define PES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("label failed");
`endif

// ----- rtl/pes_pkg.sv -----
// Shared types, constants and the arctangent table of the pose error scorer.
// No dependencies.
package pes_pkg;

	localparam int POS_FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS      = 24;
	localparam int CORDIC_W          = 32;
	localparam logic signed [31:0] Z_MAX = 32'sd1686629713;
	localparam logic [17:0] ROT_MAX = 18'd205887;
	localparam logic [16:0] W_ONE   = 17'd65536;

	typedef enum logic [7:0] {
		REG_TPOS_X = 8'd0,
		REG_TPOS_Y = 8'd1,
		REG_TPOS_Z = 8'd2,
		REG_TQUAT_X = 8'd3,
		REG_TQUAT_Y = 8'd4,
		REG_TQUAT_Z = 8'd5,
		REG_TQUAT_W = 8'd6,
		REG_ROT_WEIGHT = 8'd7
	} reg_index_t;

	// atan(2^-k) in Q.30, truncated except for k = 0, which is rounded.
	function automatic logic signed [31:0] atan_q30(input int k);
		logic signed [31:0] v;
		case (k)
			0: v = 32'sd843314857;
			1: v = 32'sd497837829;
			2: v = 32'sd263043836;
			3: v = 32'sd133525158;
			4: v = 32'sd67021686;
			5: v = 32'sd33543515;
			6: v = 32'sd16775850;
			7: v = 32'sd8388437;
			8: v = 32'sd4194282;
			9: v = 32'sd2097149;
			10: v = 32'sd1048575;
			11: v = 32'sd524287;
			12: v = 32'sd262143;
			13: v = 32'sd131071;
			14: v = 32'sd65535;
			15: v = 32'sd32767;
			16: v = 32'sd16383;
			17: v = 32'sd8191;
			18: v = 32'sd4095;
			19: v = 32'sd2047;
			20: v = 32'sd1023;
			21: v = 32'sd511;
			22: v = 32'sd255;
			23: v = 32'sd127;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/pose_error_scorer.sv -----
// Pose error scorer top level: configuration registers, front-end arithmetic,
// root and CORDIC pipelines, and score stage. Depends on pes_pkg, pes_sqrt_pipe
// and pes_cordic_pipe.
//
// Usage: the target pose and rotation weight are written over the cfg channel
// (index 0..7 in register order; other indexes are ignored, cfg_ready is
// always high). The user must write configuration only while no transfer is in
// flight, which the block does not enforce. Each transfer on the s_ channel
// carries one current pose and time stamp and yields exactly one transfer on
// the m_ channel with the score, the position distance, the rotation angle and
// the time stamp. Throughput is one item per cycle while m_tready is not held
// low. From an accepted input to m_tvalid an item passes three front-end
// stages (differences and quaternion products, squares and dot clamp, sums),
// 33 stages for the distance root, 29 for the dot-product complement root, 24
// CORDIC steps and two score stages, the last of which is the output register.
// All stages advance together: when the receiver holds m_tready low while a
// result is shown, the whole pipeline holds and s_tready drops, so nothing is
// lost or repeated. Empty slots do not hold the pipeline back.
// Reset clears every valid bit and loads the register reset values.
module pose_error_scorer #(
	parameter int POS_FRAC_BITS = pes_pkg::POS_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cur_pos_x, cur_pos_y, cur_pos_z, cur_quat_x, cur_quat_y, cur_quat_z,
	// cur_quat_w, sample_time_ms (lowest bits first)
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pose_score, position_error, rotation_error, result_time_ms, 4 zero bits
	output logic [119:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import pes_pkg::*;

	localparam int SH_R = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
	localparam int SH_L = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;

	// Configuration registers.
	logic signed [31:0] tpos_q [3];
	logic signed [15:0] tquat_q [4];
	logic [16:0]        weight_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpos_q[0]  <= '0;
			tpos_q[1]  <= '0;
			tpos_q[2]  <= '0;
			tquat_q[0] <= '0;
			tquat_q[1] <= '0;
			tquat_q[2] <= '0;
			tquat_q[3] <= 16'sd16384;
			weight_q   <= 17'd32768;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TPOS_X:     tpos_q[0]  <= cfg_data;
				REG_TPOS_Y:     tpos_q[1]  <= cfg_data;
				REG_TPOS_Z:     tpos_q[2]  <= cfg_data;
				REG_TQUAT_X:    tquat_q[0] <= cfg_data[15:0];
				REG_TQUAT_Y:    tquat_q[1] <= cfg_data[15:0];
				REG_TQUAT_Z:    tquat_q[2] <= cfg_data[15:0];
				REG_TQUAT_W:    tquat_q[3] <= cfg_data[15:0];
				REG_ROT_WEIGHT: weight_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// One enable for every stage: advance unless a shown result is stalled.
	logic en;
	assign en       = m_tready || !m_tvalid;
	assign s_tready = en;

	// Stage 1: absolute position differences and quaternion products.
	logic               valid_s1, valid_s2, valid_s3;
	logic [32:0]        mag_s1 [3];
	logic signed [31:0] prod_s1 [4];
	logic [31:0]        time_s1, time_s2, time_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	logic signed [32:0] diff [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = $signed({s_tdata[32*k+31], s_tdata[32*k +: 32]})
				- $signed({tpos_q[k][31], tpos_q[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mag_s1[k] <= diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
			end
			for (int k = 0; k < 4; k++) begin
				prod_s1[k] <= $signed(s_tdata[96+16*k +: 16]) * tquat_q[k];
			end
			time_s1 <= s_tdata[191:160];
		end
	end

	// Stage 2: squares of the differences, dot product made absolute and clamped.
	logic [65:0]        sq_s2 [3];
	logic [28:0]        dot_s2, dot_s3;
	logic signed [33:0] dot_sum;
	logic [33:0]        dot_abs;

	always_comb begin
		dot_sum = 34'(prod_s1[0]) + 34'(prod_s1[1]) + 34'(prod_s1[2]) + 34'(prod_s1[3]);
		dot_abs = dot_sum[33] ? 34'(-dot_sum) : 34'(dot_sum);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= mag_s1[k] * mag_s1[k];
			end
			dot_s2  <= (dot_abs > 34'(1 << 28)) ? 29'(1 << 28) : dot_abs[28:0];
			time_s2 <= time_s1;
		end
	end

	// Stage 3: sum of squares and the radicand 1 - dot^2 in Q.56.
	logic [65:0] sumsq_s3;
	logic [56:0] rad2_s3;
	logic [57:0] dot_sq;
	assign dot_sq = dot_s2 * dot_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sumsq_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			rad2_s3  <= 57'(58'(1) << 56) - dot_sq[56:0];
			dot_s3   <= dot_s2;
			time_s3  <= time_s2;
		end
	end

	// Distance root; the rotation inputs and time stamp ride along as sideband.
	logic        dist_valid;
	logic [32:0] dist_root;
	logic [117:0] dist_sb;

	pes_sqrt_pipe #(.RAD_W(66), .ROOT_W(33), .SB_W(118)) u_dist_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_rad    (sumsq_s3),
		.in_sb     ({rad2_s3, dot_s3, time_s3}),
		.out_valid (dist_valid),
		.out_root  (dist_root),
		.out_sb    (dist_sb)
	);

	// Bring the distance to 16 fraction bits and saturate.
	logic [40:0] dist_wide;
	logic [32:0] dist_fix;
	assign dist_wide = ({8'd0, dist_root} >> SH_R) << SH_L;
	assign dist_fix  = (dist_wide > 41'h1FFFFFFFF) ? 33'h1FFFFFFFF : dist_wide[32:0];

	// Root of 1 - dot^2, giving the sine leg of the angle.
	logic        sin_valid;
	logic [28:0] sin_root;
	logic [93:0] sin_sb;

	pes_sqrt_pipe #(.RAD_W(57), .ROOT_W(29), .SB_W(94)) u_sin_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dist_valid),
		.in_rad    (dist_sb[117:61]),
		.in_sb     ({dist_fix, dist_sb[60:0]}),
		.out_valid (sin_valid),
		.out_root  (sin_root),
		.out_sb    (sin_sb)
	);

	// Angle by CORDIC vectoring on (dot, sine).
	logic                       ang_valid;
	logic signed [CORDIC_W-1:0] ang_z;
	logic [64:0]                ang_sb;

	pes_cordic_pipe #(.SB_W(65)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sin_valid),
		.in_x      (sin_sb[60:32]),
		.in_y      (sin_root),
		.in_sb     ({sin_sb[93:61], sin_sb[31:0]}),
		.out_valid (ang_valid),
		.out_z     (ang_z),
		.out_sb    (ang_sb)
	);

	// Stage 4: angle clamp to Q2.16, weighted products.
	logic signed [CORDIC_W-1:0] z_clamp;
	logic [17:0] rot_cur;
	logic [16:0] w_eff;
	logic        valid_s4, valid_s5;
	logic [49:0] pa_s4;
	logic [34:0] pb_s4;
	logic [32:0] dist_s4, dist_s5;
	logic [17:0] rot_s4, rot_s5;
	logic [31:0] time_s4, time_s5;
	logic [32:0] score_s5;
	logic [50:0] score_sum;

	always_comb begin
		if (ang_z[CORDIC_W-1]) begin
			z_clamp = '0;
		end else if (ang_z > Z_MAX) begin
			z_clamp = Z_MAX;
		end else begin
			z_clamp = ang_z;
		end
		rot_cur = (z_clamp[30:13] > ROT_MAX) ? ROT_MAX : z_clamp[30:13];
		w_eff   = (weight_q > W_ONE) ? W_ONE : weight_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= ang_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s4   <= (W_ONE - w_eff) * ang_sb[64:32];
			pb_s4   <= w_eff * rot_cur;
			dist_s4 <= ang_sb[64:32];
			rot_s4  <= rot_cur;
			time_s4 <= ang_sb[31:0];
		end
	end

	// Stage 5: score sum, shift and saturation; this is the output register.
	assign score_sum = 51'(pa_s4) + 51'(pb_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			score_s5 <= (score_sum[50:16] > 35'h1FFFFFFFF) ? 33'h1FFFFFFFF
				: score_sum[48:16];
			dist_s5  <= dist_s4;
			rot_s5   <= rot_s4;
			time_s5  <= time_s4;
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = {4'd0, time_s5, rot_s5, dist_s5, score_s5};
endmodule

// ----- rtl/pes_sqrt_pipe.sv -----
// Pipelined floor square root, one root bit per register stage, with sideband.
// No dependencies.
module pes_sqrt_pipe #(
	parameter int RAD_W  = 66,
	parameter int ROOT_W = 33,
	parameter int SB_W   = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  in_rad,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output logic [SB_W-1:0]   out_sb
);
	localparam int RW = RAD_W + 1;

	logic              valid_s [ROOT_W+1];
	logic [RW-1:0]     rem_s   [ROOT_W+1];
	logic [ROOT_W-1:0] root_s  [ROOT_W+1];
	logic [SB_W-1:0]   sb_s    [ROOT_W+1];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = {1'b0, in_rad};
	assign root_s[0]  = '0;
	assign sb_s[0]    = in_sb;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		localparam int B = ROOT_W - 1 - i;
		logic [RW-1:0] cand;
		logic          take;
		// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
		assign cand = (RW'(root_s[i]) << (B + 1)) + (RW'(1) << (2 * B));
		assign take = rem_s[i] >= cand;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? rem_s[i] - cand : rem_s[i];
				root_s[i+1] <= take ? (root_s[i] | (ROOT_W'(1) << B)) : root_s[i];
				sb_s[i+1]   <= sb_s[i];
			end
		end
	end

	assign out_valid = valid_s[ROOT_W];
	assign out_root  = root_s[ROOT_W];
	assign out_sb    = sb_s[ROOT_W];
endmodule

// ----- rtl/pes_cordic_pipe.sv -----
// Pipelined CORDIC vectoring, one rotation step per register stage, with sideband.
// Depends on pes_pkg for the step count, word width and arctangent table.
module pes_cordic_pipe #(
	parameter int SB_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [28:0]                     in_x,
	input  logic [28:0]                     in_y,
	input  logic [SB_W-1:0]                 in_sb,
	output logic                            out_valid,
	output logic signed [pes_pkg::CORDIC_W-1:0] out_z,
	output logic [SB_W-1:0]                 out_sb
);
	import pes_pkg::*;

	logic                       valid_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] x_s     [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] y_s     [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] z_s     [CORDIC_STEPS+1];
	logic [SB_W-1:0]            sb_s    [CORDIC_STEPS+1];

	assign valid_s[0] = in_valid;
	assign x_s[0]     = CORDIC_W'(in_x);
	assign y_s[0]     = CORDIC_W'(in_y);
	assign z_s[0]     = '0;
	assign sb_s[0]    = in_sb;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		logic signed [CORDIC_W-1:0] xs, ys;
		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[k][CORDIC_W-1]) begin
					x_s[k+1] <= x_s[k] + ys;
					y_s[k+1] <= y_s[k] - xs;
					z_s[k+1] <= z_s[k] + atan_q30(k);
				end else begin
					x_s[k+1] <= x_s[k] - ys;
					y_s[k+1] <= y_s[k] + xs;
					z_s[k+1] <= z_s[k] - atan_q30(k);
				end
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	assign out_valid = valid_s[CORDIC_STEPS];
	assign out_z     = z_s[CORDIC_STEPS];
	assign out_sb    = sb_s[CORDIC_STEPS];
endmodule

// ----- rtl/pes_checker.sv -----
// Port-level checker for the pose error scorer, bound to the top level.
// Depends on pose_error_scorer_macros.svh.
`include "pose_error_scorer_macros.svh"
module pes_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready
);
	// A stalled result stays shown and unchanged.
	`PES_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`PES_ASSERT_NEXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	// The input side only stalls behind a stalled result.
	`PES_ASSERT_NOW(a_ready_free, clk, arst_n, !m_tvalid || m_tready, s_tready)
	// The angle never exceeds pi in Q2.16.
	`PES_ASSERT_NOW(a_rot_cap, clk, arst_n, m_tvalid, m_tdata[83:66] <= 18'd205887)
	// Configuration writes are never refused.
	`PES_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)
endmodule

bind pose_error_scorer pes_checker u_pes_checker (.*);

// ----- dv/tb_pose_error_scorer.sv -----
// Self-checking testbench for pose_error_scorer: directed and random poses under
// several target and weight settings, with random stalls on both stream sides.
// Depends on pes_pkg and the pose_error_scorer RTL.
module tb_pose_error_scorer;
	import pes_pkg::*;

	// Register indexes past the list; the block must drop these writes.
	localparam logic [7:0] IDX_UNUSED_LO = 8'd8;
	localparam logic [7:0] IDX_UNUSED_HI = 8'd255;
	localparam logic [32:0] OUT33_MAX = {33{1'b1}};
	localparam longint Q28_ONE = 64'sd1 << 28;
	localparam longint Z_LIMIT = 64'sd1686629713;

	typedef struct packed {
		logic [31:0] t;
		logic signed [15:0] qw, qz, qy, qx;
		logic signed [31:0] pz, py, px;
	} pose_t;

	// Members from the top down, so the score lands in the lowest bits.
	typedef struct packed {
		logic [31:0] t;
		logic [17:0] ang;
		logic [32:0] pos_err;
		logic [32:0] score;
	} score_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// cur_pos_x, cur_pos_y, cur_pos_z, cur_quat_x, cur_quat_y, cur_quat_z,
	// cur_quat_w, sample_time_ms (lowest bits first)
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// pose_score, position_error, rotation_error, result_time_ms, 4 zero bits
	logic [119:0] m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_index;
	logic [31:0]  cfg_data;

	pose_error_scorer uut (.*);

	// Our own copy of the eight registers, kept at their register widths.
	logic signed [31:0] tgt_pos [3];
	logic signed [15:0] tgt_quat [4];
	logic [16:0]        rot_weight;

	score_t pending_scores [$];
	int     fail_count;
	int     items_sent;
	int     results_seen;
	int     cfg_writes;
	bit     idle_on;
	int     hold_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Generous ceiling: the slowest correct run is far below this.
	initial begin
		#(8 * 1500000);
		$display("FAIL pose_error_scorer");
		$finish;
	end

	// Floor square root of a value below 2^66; the root always fits in 33 bits.
	function automatic logic [32:0] root_floor(input logic [67:0] v);
		logic [67:0] root;
		logic [67:0] cand;
		root = '0;
		for (int b = 32; b >= 0; b--) begin
			cand = root | (68'd1 << b);
			if (cand * cand <= v)
				root = cand;
		end
		return root[32:0];
	endfunction

	// Distance, rotation angle and weighted score for one pose under the
	// current target and weight.
	function automatic score_t score_pose(input pose_t p);
		score_t r;
		logic signed [31:0] cur [3];
		logic signed [15:0] cq [4];
		longint diff, dot, x, y, z, xs, ys;
		logic [67:0] sumsq;
		logic [32:0] mag;
		logic [63:0] w, acc;
		cur = '{p.px, p.py, p.pz};
		cq = '{p.qx, p.qy, p.qz, p.qw};
		sumsq = '0;
		for (int k = 0; k < 3; k++) begin
			diff = longint'(cur[k]) - longint'(tgt_pos[k]);
			mag = (diff < 0) ? 33'(-diff) : 33'(diff);
			sumsq += 68'(mag) * 68'(mag);
		end
		r.pos_err = root_floor(sumsq);

		// Dot product of the two quaternions in Q2.28, folded and clamped to one.
		dot = 0;
		for (int k = 0; k < 4; k++)
			dot += longint'(tgt_quat[k]) * longint'(cq[k]);
		if (dot < 0)
			dot = -dot;
		if (dot > Q28_ONE)
			dot = Q28_ONE;
		x = dot;
		y = longint'(root_floor(68'(Q28_ONE * Q28_ONE - dot * dot)));
		z = 0;
		// CORDIC vectoring drives y to zero and accumulates the half angle.
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += longint'(atan_q30(k));
			end else begin
				x -= ys;
				y += xs;
				z -= longint'(atan_q30(k));
			end
		end
		if (z < 0)
			z = 0;
		if (z > Z_LIMIT)
			z = Z_LIMIT;
		z = z >>> 13;
		r.ang = (z > longint'(ROT_MAX)) ? ROT_MAX : 18'(z);

		w = (rot_weight > W_ONE) ? 64'(W_ONE) : 64'(rot_weight);
		acc = ((64'(W_ONE) - w) * 64'(r.pos_err) + w * 64'(r.ang)) >> 16;
		r.score = (acc > 64'(OUT33_MAX)) ? OUT33_MAX : acc[32:0];
		r.t = p.t;
		return r;
	endfunction

	// One configuration transfer; the local copy follows only valid indexes.
	task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_TPOS_X:     tgt_pos[0] = val;
			REG_TPOS_Y:     tgt_pos[1] = val;
			REG_TPOS_Z:     tgt_pos[2] = val;
			REG_TQUAT_X:    tgt_quat[0] = val[15:0];
			REG_TQUAT_Y:    tgt_quat[1] = val[15:0];
			REG_TQUAT_Z:    tgt_quat[2] = val[15:0];
			REG_TQUAT_W:    tgt_quat[3] = val[15:0];
			REG_ROT_WEIGHT: rot_weight = val[16:0];
			default: ;
		endcase
	endtask

	// Registers change only with the pipeline empty; every item yields a result,
	// so an empty queue means nothing is in flight. The sender stops offering
	// first so the last pose is not taken a second time.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_target(input logic [31:0] px, py, pz,
			input logic [15:0] qx, qy, qz, qw, input logic [31:0] w);
		drain();
		write_reg(REG_TPOS_X, px);
		write_reg(REG_TPOS_Y, py);
		write_reg(REG_TPOS_Z, pz);
		write_reg(REG_TQUAT_X, {{16{qx[15]}}, qx});
		write_reg(REG_TQUAT_Y, {{16{qy[15]}}, qy});
		write_reg(REG_TQUAT_Z, {{16{qz[15]}}, qz});
		write_reg(REG_TQUAT_W, {{16{qw[15]}}, qw});
		write_reg(REG_ROT_WEIGHT, w);
	endtask

	// Sends one pose. The valid stays high across back-to-back transfers and is
	// dropped only when a sender gap is taken.
	task automatic send_pose(input pose_t p);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tdata  <= {p.t, p.qw, p.qz, p.qy, p.qx, p.pz, p.py, p.px};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_scores.insert(pending_scores.size(), score_pose(p));
		items_sent++;
	endtask

	function automatic logic signed [15:0] rand_quat_comp;
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	// Random pose: mostly near the target so distance and angle stay moderate,
	// sometimes anywhere in the full field ranges.
	function automatic pose_t rand_pose;
		pose_t p;
		int spread;
		spread = $urandom_range(0, 3);
		if (spread == 0) begin
			p.px = $urandom;
			p.py = $urandom;
			p.pz = $urandom;
		end else begin
			p.px = tgt_pos[0] + 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			p.py = tgt_pos[1] + 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			p.pz = tgt_pos[2] + 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
		end
		if ($urandom_range(0, 2) == 0) begin
			// Small rotation away from the target, sign flipped at random.
			p.qx = tgt_quat[0] + 16'(int'($urandom_range(0, 800)) - 400);
			p.qy = tgt_quat[1] + 16'(int'($urandom_range(0, 800)) - 400);
			p.qz = tgt_quat[2] + 16'(int'($urandom_range(0, 800)) - 400);
			p.qw = tgt_quat[3] + 16'(int'($urandom_range(0, 800)) - 400);
			if ($urandom_range(0, 1) == 1)
				{p.qx, p.qy, p.qz, p.qw} = {-p.qx, -p.qy, -p.qz, -p.qw};
		end else begin
			p.qx = rand_quat_comp();
			p.qy = rand_quat_comp();
			p.qz = rand_quat_comp();
			p.qw = rand_quat_comp();
		end
		p.t = $urandom;
		return p;
	endfunction

	function automatic pose_t make_pose(input logic [31:0] px, py, pz,
			input logic [15:0] qx, qy, qz, qw, input logic [31:0] t);
		pose_t p;
		p = '{t, qw, qz, qy, qx, pz, py, px};
		return p;
	endfunction

	// Output side: random stall bursts, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Result checker: every transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		score_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[115:0];
			results_seen++;
			if (pending_scores.size() == 0) begin
				$error("unexpected result transfer: %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_scores.pop_front();
				if (got.score !== want.score) begin
					$error("pose_score: expected %0d, got %0d", want.score, got.score);
					fail_count++;
				end
				if (got.pos_err !== want.pos_err) begin
					$error("position_error: expected %0d, got %0d", want.pos_err,
						got.pos_err);
					fail_count++;
				end
				if (got.ang !== want.ang) begin
					$error("rotation_error: expected %0d, got %0d", want.ang, got.ang);
					fail_count++;
				end
				if (got.t !== want.t) begin
					$error("result_time_ms: expected %0d, got %0d", want.t, got.t);
					fail_count++;
				end
			end
		end
	end

	// Reset values: zero target, identity quaternion, half weight.
	task automatic test_reset_values;
		send_pose(make_pose(0, 0, 0, 0, 0, 0, 16384, 0));
		send_pose(make_pose(32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000,
			0, 16384, 0, 0, 32'hFFFF_FFFF));
		send_pose(make_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			-16384, 0, 0, 0, 32'h5555_AAAA));
	endtask

	// Field extremes, largest distance, opposite, perpendicular and
	// out-of-range quaternions, dot products past one.
	task automatic test_field_extremes;
		set_target(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			16384, 16384, 16384, 16384, 32'd40000);
		send_pose(make_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			16384, 16384, 16384, 16384, 32'hAAAA_5555));
		send_pose(make_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			-16384, -16384, -16384, -16384, 32'd1));
		send_pose(make_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd0));
		send_pose(make_pose(32'h8000_0001, 32'h8000_0000, 32'h8000_0000,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF));
		send_pose(make_pose(0, 0, 0, 16384, -16384, 16384, -16384, 32'd2));
		send_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 32'd3));
		set_target(0, 0, 0, 0, 0, 0, 16384, 32'd65536);
		send_pose(make_pose(0, 0, 0, 0, 0, 0, -16384, 32'd4));
		send_pose(make_pose(0, 0, 0, 16384, 0, 0, 0, 32'd5));
		send_pose(make_pose(32'h0000_0001, 0, 0, 0, 11585, 0, 11585, 32'd6));
		send_pose(make_pose(0, 0, 0, 0, 0, 0, 16383, 32'd7));
	endtask

	// Weight at zero, above one (used as one) and at its largest register value,
	// plus writes to indexes past the list, which must change nothing.
	task automatic test_weight_edges;
		set_target(32'h0010_0000, 32'hFFF0_0000, 32'h0, 0, 16384, 0, 0, 32'd0);
		write_reg(IDX_UNUSED_LO, 32'hDEAD_BEEF);
		write_reg(IDX_UNUSED_HI, 32'h1234_5678);
		send_pose(make_pose(0, 0, 0, 0, 0, 16384, 0, 32'd8));
		send_pose(make_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			16384, 0, 0, 0, 32'd9));
		drain();
		write_reg(REG_ROT_WEIGHT, 32'h0001_FFFF);
		send_pose(make_pose(0, 0, 0, 0, 0, 16384, 0, 32'd10));
		send_pose(make_pose(32'h1234_5678, 0, 0, 0, 0, 0, -16384, 32'd11));
		drain();
		write_reg(REG_ROT_WEIGHT, 32'hFFFF_0001);
		send_pose(make_pose(0, 0, 0, 16384, 0, 0, 0, 32'd12));
		send_pose(make_pose(32'h8000_0000, 0, 0, 0, 0, 0, 16384, 32'd13));
	endtask

	task automatic test_random_poses(input int count);
		repeat (count)
			send_pose(rand_pose());
	endtask

	// The receiver holds off for a long stretch while poses keep coming, so the
	// pipeline fills and the input side must stall without losing anything.
	task automatic test_full_pipeline;
		drain();
		hold_cycles = 400;
		repeat (200)
			send_pose(rand_pose());
	endtask

	task automatic random_target;
		set_target($urandom, $urandom, $urandom, rand_quat_comp(), rand_quat_comp(),
			rand_quat_comp(), rand_quat_comp(), $urandom_range(0, 65536));
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		fail_count  = 0;
		items_sent  = 0;
		results_seen = 0;
		cfg_writes  = 0;
		hold_cycles = 0;
		idle_on     = 1'b1;
		tgt_pos     = '{0, 0, 0};
		tgt_quat    = '{0, 0, 0, 16384};
		rot_weight  = 17'd32768;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_field_extremes();
		test_weight_edges();
		test_random_poses(300);
		set_target(0, 0, 0, 0, 0, 0, 16384, 32'd0);
		test_random_poses(200);
		set_target(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, -16384, 0, 0, 0, 32'd65536);
		test_random_poses(200);
		random_target();
		test_full_pipeline();
		random_target();
		test_random_poses(300);
		random_target();
		test_random_poses(300);
		// Final stretch at full rate on both sides.
		random_target();
		idle_on = 1'b0;
		test_random_poses(330);
		s_tvalid <= 1'b0;

		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		$display("Covered %0d poses and %0d results over %0d register writes,",
			items_sent, results_seen, cfg_writes);
		$display("including field extremes, weight limits and a full-pipeline stall.");
		if (fail_count == 0) begin
			$display("PASS pose_error_scorer");
		end else begin
			$display("FAIL pose_error_scorer");
		end
		$finish;
	end

endmodule
